FILE: sv/cbt_pkg.sv
package cbt_pkg;

   // field widths
   localparam int COORD_W        = 32;
   localparam int WEIGHT_W       = 17;
   localparam int FRAC_W         = 16;
   localparam int NUMBER_W       = 6;
   localparam int AXES           = 3;
   localparam int CTRL_PTS       = 4;
   localparam int POINTS_DEFAULT = 20;
   localparam int POINTS_MIN     = 2;
   localparam int POINTS_MAX     = 64;

   // datapath widths
   localparam int PROD_W = COORD_W + WEIGHT_W;
   localparam int RND_W  = PROD_W - FRAC_W;
   localparam int PAIR_W = RND_W + 1;
   localparam int SUM_W  = RND_W + 2;

   // stream widths
   localparam int REQ_TDATA_W = CTRL_PTS * AXES * COORD_W;
   localparam int RSP_BITS    = AXES * COORD_W + NUMBER_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [WEIGHT_W-1:0]       weight_type;

   typedef struct packed {
      logic                valid;
      logic [NUMBER_W-1:0] number;
      logic                last;
   } tag_type;

endpackage

FILE: sv/cbt_seq.sv
module cbt_seq
   import cbt_pkg::*;
#(
   parameter int POINTS_PER_CURVE = POINTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       ce,
   input  logic       req_valid,
   output logic       req_ready,
   input  coord_type  req_cp [AXES][CTRL_PTS],
   output tag_type    s1_tag,
   output coord_type  s1_cp [AXES][CTRL_PTS],
   output weight_type s1_w [CTRL_PTS]
);

   localparam int NPTS = (POINTS_PER_CURVE < POINTS_MIN) ? POINTS_MIN :
                         ((POINTS_PER_CURVE > POINTS_MAX) ? POINTS_MAX : POINTS_PER_CURVE);
   localparam int D    = NPTS - 1;
   localparam int JW   = $clog2(NPTS);
   localparam longint unsigned DC = longint'(D) * longint'(D) * longint'(D);

   // bernstein weights per sample, rounded once at elaboration
   weight_type wtab [NPTS][CTRL_PTS];

   for (genvar g = 0; g < NPTS; g++) begin : g_wt
      localparam longint unsigned R  = longint'(D - g);
      localparam longint unsigned J  = longint'(g);
      localparam longint unsigned K0 = R * R * R;
      localparam longint unsigned K1 = 3 * R * R * J;
      localparam longint unsigned K2 = 3 * R * J * J;
      localparam longint unsigned K3 = J * J * J;
      localparam longint unsigned W0 = (K0 * 65536 + DC / 2) / DC;
      localparam longint unsigned W1 = (K1 * 65536 + DC / 2) / DC;
      localparam longint unsigned W2 = (K2 * 65536 + DC / 2) / DC;
      localparam longint unsigned W3 = (K3 * 65536 + DC / 2) / DC;
      assign wtab[g][0] = WEIGHT_W'(W0);
      assign wtab[g][1] = WEIGHT_W'(W1);
      assign wtab[g][2] = WEIGHT_W'(W2);
      assign wtab[g][3] = WEIGHT_W'(W3);
   end

   logic            busy_ff, busy_in;
   logic [JW-1:0]   j_ff, j_in;
   tag_type         tag_ff, tag_in;
   coord_type       cp_ff [AXES][CTRL_PTS];
   coord_type       cp_in [AXES][CTRL_PTS];
   coord_type       s1_cp_ff [AXES][CTRL_PTS];
   coord_type       s1_cp_in [AXES][CTRL_PTS];
   weight_type      s1_w_ff [CTRL_PTS];
   weight_type      s1_w_in [CTRL_PTS];
   logic            last_j;
   logic            take;
   logic            issue;

   assign last_j    = (j_ff == JW'(D));
   assign req_ready = !busy_ff || (ce && last_j);
   assign take      = req_valid && req_ready;
   assign issue     = ce && busy_ff;

   always_comb begin
      busy_in = busy_ff;
      j_in    = j_ff;
      tag_in  = tag_ff;
      if (ce) begin
         tag_in = '0;
         if (busy_ff) begin
            tag_in.valid  = 1'b1;
            tag_in.number = NUMBER_W'(j_ff);
            tag_in.last   = last_j;
            if (last_j) begin
               busy_in = 1'b0;
            end else begin
               j_in = JW'(j_ff + 1'b1);
            end
         end
      end
      if (take) begin
         busy_in = 1'b1;
         j_in    = '0;
      end
   end

   always_comb begin
      cp_in    = cp_ff;
      s1_cp_in = s1_cp_ff;
      s1_w_in  = s1_w_ff;
      if (take) begin
         cp_in = req_cp;
      end
      if (issue) begin
         s1_cp_in = cp_ff;
         for (int i = 0; i < CTRL_PTS; i++) begin
            s1_w_in[i] = wtab[j_ff][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         j_ff    <= '0;
         tag_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         j_ff    <= j_in;
         tag_ff  <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff    <= cp_in;
      s1_cp_ff <= s1_cp_in;
      s1_w_ff  <= s1_w_in;
   end

   assign s1_tag = tag_ff;
   assign s1_cp  = s1_cp_ff;
   assign s1_w   = s1_w_ff;

endmodule

FILE: sv/cbt_axis.sv
module cbt_axis
   import cbt_pkg::*;
(
   input  logic       clock,
   input  logic       ce,
   input  coord_type  cp [CTRL_PTS],
   input  weight_type w [CTRL_PTS],
   output coord_type  point
);

   localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(1) << (FRAC_W - 1);
   localparam logic signed [SUM_W-1:0]  MAX_C =
      {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  MIN_C =
      {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff [CTRL_PTS];
   logic signed [PROD_W-1:0] prod_in [CTRL_PTS];
   logic signed [RND_W-1:0]  rnd_ff [CTRL_PTS];
   logic signed [RND_W-1:0]  rnd_in [CTRL_PTS];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  total;

   // coordinate times weight, round half up back to q16.16
   always_comb begin
      for (int i = 0; i < CTRL_PTS; i++) begin
         prod_in[i] = cp[i] * $signed({1'b0, w[i]});
         rnd_in[i]  = RND_W'((prod_ff[i] + HALF) >>> FRAC_W);
      end
      pair_in[0] = rnd_ff[0] + rnd_ff[1];
      pair_in[1] = rnd_ff[2] + rnd_ff[3];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         prod_ff <= prod_in;
         rnd_ff  <= rnd_in;
         pair_ff <= pair_in;
      end
   end

   // final add and clamp to the signed 32-bit range
   always_comb begin
      total = pair_ff[0] + pair_ff[1];
      if (total > MAX_C) begin
         point = COORD_W'(MAX_C);
      end else if (total < MIN_C) begin
         point = COORD_W'(MIN_C);
      end else begin
         point = COORD_W'(total);
      end
   end

endmodule

FILE: sv/cubic_bezier_tessellator_unit.sv
// path to rsp: request register, s1 weight stage, product, round, pair sum, output register
// throughput: one point per cycle while rsp_tready does not stall the output; a curve
//    gives POINTS_PER_CURVE points (clamped to 2..64), and the next request is taken in the
//    cycle its predecessor's last point issues, so the single sample sequencer runs gapless
// reset: synchronous, active high; clears the sequencer and all valid bits
module cubic_bezier_tessellator_unit
   import cbt_pkg::*;
#(
   parameter int POINTS_PER_CURVE = POINTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: four control points of one curve
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response: one curve point per beat
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // point_x, point_y, point_z, point_number, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // last_point
   output logic                   rsp_tlast
);

   // global pipeline advance: output register empty or being drained
   logic       ce;

   coord_type  req_cp [AXES][CTRL_PTS];
   tag_type    s1_tag;
   coord_type  s1_cp [AXES][CTRL_PTS];
   weight_type s1_w [CTRL_PTS];
   coord_type  point [AXES];

   // tags ride alongside the axis datapath stages
   tag_type    tag2_ff, tag2_in;
   tag_type    tag3_ff, tag3_in;
   tag_type    tag4_ff, tag4_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   coord_type           rsp_point_ff [AXES];
   coord_type           rsp_point_in [AXES];
   logic [NUMBER_W-1:0] rsp_number_ff, rsp_number_in;
   logic                rsp_last_ff, rsp_last_in;

   assign ce = !rsp_valid_ff || rsp_tready;

   // unpack request, p0_x in the lowest bits
   for (genvar i = 0; i < CTRL_PTS; i++) begin : g_pt
      for (genvar a = 0; a < AXES; a++) begin : g_ax
         assign req_cp[a][i] = req_tdata[(i*AXES + a)*COORD_W +: COORD_W];
      end
   end

   // sample sequencer and weight lookup
   cbt_seq #(
      .POINTS_PER_CURVE (POINTS_PER_CURVE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cp    (req_cp),
      .s1_tag    (s1_tag),
      .s1_cp     (s1_cp),
      .s1_w      (s1_w)
   );

   // per-axis multiply, round and saturating sum
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      cbt_axis u_axis (
         .clock (clock),
         .ce    (ce),
         .cp    (s1_cp[a]),
         .w     (s1_w),
         .point (point[a])
      );
   end

   always_comb begin
      tag2_in       = ce ? s1_tag  : tag2_ff;
      tag3_in       = ce ? tag2_ff : tag3_ff;
      tag4_in       = ce ? tag3_ff : tag4_ff;
      rsp_valid_in  = ce ? tag4_ff.valid  : rsp_valid_ff;
      rsp_number_in = ce ? tag4_ff.number : rsp_number_ff;
      rsp_last_in   = ce ? tag4_ff.last   : rsp_last_ff;
      rsp_point_in  = rsp_point_ff;
      if (ce) begin
         rsp_point_in = point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         tag4_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag2_ff      <= tag2_in;
         tag3_ff      <= tag3_in;
         tag4_ff      <= tag4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_point_ff  <= rsp_point_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_number_ff,
                        rsp_point_ff[2], rsp_point_ff[1], rsp_point_ff[0]};
   assign rsp_tlast  = rsp_last_ff;

endmodule
